>>> rtl/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
// Used by pfa_ctrl, pfa_dp and page_frame_allocator; depends on nothing.
package pfa_pkg;

  // Field widths and stack geometry
  localparam int PAGE_W      = 44;
  localparam int STATUS_W    = 3;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'b1;

  // Request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2
  } pfa_mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EXHAUSTED    = 3'd1,
    ST_NEVER_GIVEN  = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_STACK_FULL   = 3'd4
  } pfa_status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_SCAN,
    S_RESULT
  } pfa_state_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_FRESH,
    OP_EXHAUST,
    OP_POP_RD,
    OP_POP_TAKE,
    OP_REJECT_NEW,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_HIT,
    OP_PUSH,
    OP_FULL,
    OP_NOP_OK
  } pfa_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_req;
    pfa_op_t op;
    logic    out_load;
  } pfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    pfa_mode_t mode;
    logic      stack_empty;
    logic      stack_full;
    logic      fresh_avail;
    logic      never_given;
    logic      scan_hit;
    logic      scan_last;
    logic      out_free;
  } pfa_sts_t;

endpackage

>>> rtl/pfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pfa_dp.sv
// Datapath of the page frame allocator: config registers, bump pointer,
// recycle stack (in pfa_ram), scan index and result registers. Uses pfa_pkg.
module pfa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfa_pkg::pfa_cmd_t             cmd,
  output pfa_pkg::pfa_sts_t             sts,
  input  logic [pfa_pkg::MODE_W-1:0]    in_mode,
  input  logic [pfa_pkg::PAGE_W-1:0]    in_page_number,
  input  logic                          cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::PAGE_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::PAGE_W-1:0]    out_granted_page,
  output logic [pfa_pkg::STATUS_W-1:0]  out_status
);
  import pfa_pkg::*;

  logic [PAGE_W-1:0]   first_page_r, end_page_r;
  logic [PAGE_W-1:0]   next_fresh_r, next_fresh_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   scan_r, scan_nxt;
  pfa_mode_t           mode_r;
  logic [PAGE_W-1:0]   page_r;
  logic [PAGE_W-1:0]   res_page_r, res_page_nxt;
  pfa_status_t         res_status_r, res_status_nxt;
  logic                out_valid_r;
  logic [PAGE_W-1:0]   out_page_r;
  pfa_status_t         out_status_r;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr, cnt_m1;
  logic [PAGE_W-1:0]   ram_rdata;

  assign cnt_m1 = ADDR_W'(count_r - CNT_W'(1));

  // Recycle stack storage
  pfa_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(page_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Operation decode
  always_comb begin
    next_fresh_nxt = next_fresh_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[ADDR_W-1:0];
    ram_raddr      = scan_r;
    case (cmd.op)
      OP_INIT: begin
        next_fresh_nxt = first_page_r;
        count_nxt      = '0;
        res_page_nxt   = '0;
        res_status_nxt = ST_OK;
      end
      OP_FRESH: begin
        res_page_nxt   = next_fresh_r;
        res_status_nxt = ST_OK;
        next_fresh_nxt = next_fresh_r + PAGE_W'(1);
      end
      OP_EXHAUST: begin
        res_page_nxt   = '0;
        res_status_nxt = ST_EXHAUSTED;
      end
      OP_POP_RD: begin
        ram_raddr = cnt_m1;
        count_nxt = count_r - CNT_W'(1);
      end
      OP_POP_TAKE: begin
        res_page_nxt   = ram_rdata;
        res_status_nxt = ST_OK;
      end
      OP_REJECT_NEW: begin
        res_page_nxt   = '0;
        res_status_nxt = ST_NEVER_GIVEN;
      end
      OP_SCAN_START: begin
        ram_raddr = '0;
        scan_nxt  = '0;
      end
      OP_SCAN_NEXT: begin
        ram_raddr = scan_r + ADDR_W'(1);
        scan_nxt  = scan_r + ADDR_W'(1);
      end
      OP_HIT: begin
        res_page_nxt   = '0;
        res_status_nxt = ST_ALREADY_FREE;
      end
      OP_PUSH: begin
        ram_we         = 1'b1;
        count_nxt      = count_r + CNT_W'(1);
        res_page_nxt   = '0;
        res_status_nxt = ST_OK;
      end
      OP_FULL: begin
        res_page_nxt   = '0;
        res_status_nxt = ST_STACK_FULL;
      end
      OP_NOP_OK: begin
        res_page_nxt   = '0;
        res_status_nxt = ST_OK;
      end
      default: begin
      end
    endcase
  end

  // Control state: config, bump pointer, fill count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
      end_page_r   <= '0;
      next_fresh_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FIRST_PAGE) begin
        first_page_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_END_PAGE) begin
        end_page_r <= cfg_wdata;
      end
      next_fresh_r <= next_fresh_nxt;
      count_r      <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load_req) begin
      mode_r <= pfa_mode_t'(in_mode);
      page_r <= in_page_number;
    end
    if (cmd.out_load) begin
      out_page_r   <= res_page_r;
      out_status_r <= res_status_r;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.mode        = mode_r;
    sts.stack_empty = (count_r == '0);
    sts.stack_full  = (count_r == CNT_W'(STACK_DEPTH));
    sts.fresh_avail = (next_fresh_r < end_page_r);
    sts.never_given = (page_r >= next_fresh_r);
    sts.scan_hit    = (ram_rdata == page_r);
    sts.scan_last   = (scan_r == cnt_m1);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_page = out_page_r;
  assign out_status       = out_status_r;

  // The fill count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A push is only issued when there is room on the stack.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PUSH |-> count_r < CNT_W'(STACK_DEPTH))
    else $error("push onto a full stack");

  // A pop takes its data in the cycle after the read was issued.
  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_POP_TAKE |-> $past(cmd.op) == OP_POP_RD)
    else $error("pop data taken without a read");

endmodule

>>> rtl/pfa_ctrl.sv
// Controller state machine of the page frame allocator.
// Drives pfa_dp through pfa_cmd_t and reads pfa_sts_t; uses pfa_pkg.
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output pfa_pkg::pfa_cmd_t cmd,
  input  pfa_pkg::pfa_sts_t sts
);
  import pfa_pkg::*;

  pfa_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
        case (sts.mode)
          MODE_ALLOC: begin
            if (!sts.stack_empty) begin
              cmd.op    = OP_POP_RD;
              state_nxt = S_POP;
            end else if (sts.fresh_avail) begin
              cmd.op = OP_FRESH;
            end else begin
              cmd.op = OP_EXHAUST;
            end
          end
          MODE_FREE: begin
            if (sts.never_given) begin
              cmd.op = OP_REJECT_NEW;
            end else if (sts.stack_empty) begin
              cmd.op = OP_PUSH;
            end else begin
              cmd.op    = OP_SCAN_START;
              state_nxt = S_SCAN;
            end
          end
          MODE_INIT: begin
            cmd.op = OP_INIT;
          end
          default: begin
            cmd.op = OP_NOP_OK;
          end
        endcase
      end
      S_POP: begin
        cmd.op    = OP_POP_TAKE;
        state_nxt = S_RESULT;
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.op    = OP_HIT;
          state_nxt = S_RESULT;
        end else if (sts.scan_last) begin
          cmd.op    = sts.stack_full ? OP_FULL : OP_PUSH;
          state_nxt = S_RESULT;
        end else begin
          cmd.op = OP_SCAN_NEXT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The scan only runs over a non-empty stack.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !sts.stack_empty)
    else $error("scan over an empty stack");

  // A new request is taken only after the previous result left for the output.
  a_accept_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) != S_IDLE) |-> $past(cmd.out_load))
    else $error("returned to idle without loading a result");

  // A pop always passes through the decide state first.
  a_pop_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> $past(state_r) == S_DECIDE)
    else $error("pop state entered out of order");

endmodule

>>> rtl/page_frame_allocator.sv
// Top level of the page frame allocator: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl, pfa_dp and pfa_ram.
//
//  Channel   Direction  Handshake            Beat contents
//  in_       input      in_valid/in_ready    in_mode, in_page_number
//  out_      output     out_valid/out_ready  out_granted_page, out_status
//  cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// One request is in work at a time. Each passes from accept through the
// decide and result states to the output register, via a pop state when
// popping the recycle stack, or via the double-free scan, which walks the
// stack RAM one entry per cycle through its single read port.
// Reset is synchronous and clears the bump pointer, fill count and config;
// stack RAM content is left as is. The output register lets the next beat
// be accepted while a result waits on out_ready.
module page_frame_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfa_pkg::MODE_W-1:0]    in_mode,
  input  logic [pfa_pkg::PAGE_W-1:0]    in_page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::PAGE_W-1:0]    out_granted_page,
  output logic [pfa_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::PAGE_W-1:0]    cfg_wdata
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  // Sequencer
  pfa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Registers, stack and result path
  pfa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_page_number  (in_page_number),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted_page(out_granted_page),
    .out_status      (out_status)
  );

endmodule

>>> dv/tb_page_frame_allocator.sv
// Self-checking testbench for page_frame_allocator: directed and random requests.
// Predicts every grant in-line from its own allocator model and checks each beat.
// Depends on pfa_pkg and the page_frame_allocator RTL.
module tb_page_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF     = 2'd3;
  localparam logic [PAGE_W-1:0] PAGE_MAX       = '1;
  localparam int                WATCHDOG_LIMIT = 4000;
  localparam int                TARGET_ITEMS   = 1900;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;
    logic              drain;
  } page_request_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    pfa_status_t       status;
  } grant_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = MODE_ALLOC;
  logic [PAGE_W-1:0]    in_page_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PAGE_W-1:0]    out_granted_page;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_PAGE;
  logic [PAGE_W-1:0]    cfg_wdata = '0;

  // Allocator model state
  logic [PAGE_W-1:0] region_first = '0;
  logic [PAGE_W-1:0] region_end = '0;
  logic [PAGE_W-1:0] fresh_ptr = '0;
  logic [PAGE_W-1:0] recycle_copy [STACK_DEPTH];
  int unsigned       recycle_fill = 0;

  page_request_t pending_requests[$];
  grant_t        expected_grants[$];
  page_request_t next_request;
  grant_t        head_grant;

  int          requests_queued = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  page_frame_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_page (out_granted_page),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the grant for one accepted request and update the model state.
  function automatic void predict_grant(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page);
    grant_t g;
    bit     found;
    g.page = '0;
    g.status = ST_OK;
    found = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (recycle_fill != 0) begin
          recycle_fill = recycle_fill - 1;
          g.page = recycle_copy[recycle_fill];
        end else if (fresh_ptr < region_end) begin
          g.page = fresh_ptr;
          fresh_ptr = fresh_ptr + 1'b1;
        end else begin
          g.status = ST_EXHAUSTED;
        end
      end
      MODE_FREE: begin
        for (int i = 0; i < recycle_fill; i++) begin
          if (recycle_copy[i] == page) found = 1'b1;
        end
        if (page >= fresh_ptr) begin
          g.status = ST_NEVER_GIVEN;
        end else if (found) begin
          g.status = ST_ALREADY_FREE;
        end else if (recycle_fill == STACK_DEPTH) begin
          g.status = ST_STACK_FULL;
        end else begin
          recycle_copy[recycle_fill] = page;
          recycle_fill = recycle_fill + 1;
        end
      end
      MODE_INIT: begin
        fresh_ptr = region_first;
        recycle_fill = 0;
      end
      default: ;
    endcase
    expected_grants.push_back(g);
  endfunction

  function automatic logic [PAGE_W-1:0] rand_page();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[PAGE_W-1:0];
  endfunction

  // Free targets cluster around the region so that every free outcome shows up.
  function automatic logic [PAGE_W-1:0] pick_page(logic [PAGE_W-1:0] base, int unsigned span);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return base + PAGE_W'($urandom_range(0, span + 3));
    if (sel < 15) return base - PAGE_W'($urandom_range(1, 3));
    if (sel < 18) return rand_page();
    if (sel == 18) return PAGE_MAX;
    return '0;
  endfunction

  task automatic queue_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page,
                               logic drain);
    page_request_t r;
    r.mode = mode;
    r.page = page;
    r.drain = drain;
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  // Wait until every queued request has been sent and answered. The check runs
  // at the falling edge so that the driver's updates of the rising edge are seen.
  task automatic settle();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_FIRST_PAGE) region_first = val;
    else region_end = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Request driver: one beat at a time with random gaps between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_grant(in_mode, in_page_number);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        send_wait = send_steady ? 0 : $urandom_range(0, 18);
      end
      if (send_wait != 0) begin
        send_wait = send_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain && expected_grants.size() != 0)) begin
        next_request = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_request.mode;
        in_page_number <= next_request.page;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Grant monitor: random back-pressure and a field-by-field check of each beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $display("%t: unexpected grant: expected none, got page %h status %0d",
                   $time, out_granted_page, out_status);
          errors++;
        end else begin
          head_grant = expected_grants.pop_front();
          if (out_granted_page !== head_grant.page) begin
            $display("%t: granted_page mismatch: expected %h, got %h",
                     $time, head_grant.page, out_granted_page);
            errors++;
          end
          if (out_status !== head_grant.status) begin
            $display("%t: status mismatch: expected %0d, got %0d",
                     $time, head_grant.status, out_status);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 18);
      end
      if (recv_wait != 0) begin
        recv_wait = recv_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%t: no beat for %0d cycles", $time, stall_cycles);
      $display("[page_frame_allocator] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: directed requests, a full-stack pass, then random phases.
  initial begin : stimulus
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] stop;
    logic [PAGE_W:0]   sum;
    int unsigned       span;
    int unsigned       batch;
    int unsigned       sel;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the region is empty: allocate is exhausted, free never given.
    queue_request(MODE_ALLOC, PAGE_MAX, 1'b0);
    queue_request(MODE_FREE, '0, 1'b0);
    queue_request(MODE_FREE, PAGE_MAX, 1'b0);
    queue_request(MODE_UNDEF, rand_page(), 1'b0);
    queue_request(MODE_INIT, '0, 1'b0);
    queue_request(MODE_ALLOC, '0, 1'b0);
    settle();

    // Small region: bump allocation, exhaustion, double free and LIFO reuse.
    write_reg(CFG_FIRST_PAGE, 44'h10);
    write_reg(CFG_END_PAGE, 44'h14);
    queue_request(MODE_INIT, '0, 1'b0);
    repeat (5) queue_request(MODE_ALLOC, '0, 1'b0);
    queue_request(MODE_FREE, 44'h12, 1'b0);
    queue_request(MODE_FREE, 44'h12, 1'b0);
    queue_request(MODE_FREE, 44'h14, 1'b0);
    queue_request(MODE_FREE, 44'h13, 1'b1);
    repeat (3) queue_request(MODE_ALLOC, '0, 1'b0);
    queue_request(MODE_FREE, PAGE_MAX, 1'b0);
    queue_request(MODE_UNDEF, PAGE_MAX, 1'b0);
    queue_request(MODE_INIT, PAGE_MAX, 1'b0);
    queue_request(MODE_ALLOC, '0, 1'b0);
    settle();

    // Region at the very top of the page space.
    write_reg(CFG_FIRST_PAGE, PAGE_MAX - 2);
    write_reg(CFG_END_PAGE, PAGE_MAX);
    queue_request(MODE_INIT, '0, 1'b0);
    repeat (3) queue_request(MODE_ALLOC, '0, 1'b0);
    queue_request(MODE_FREE, PAGE_MAX - 1, 1'b0);
    queue_request(MODE_FREE, PAGE_MAX, 1'b0);
    queue_request(MODE_ALLOC, '0, 1'b0);
    settle();

    // Fill the recycle stack to the brim, then overflow it.
    base = rand_page() >> 1;
    write_reg(CFG_FIRST_PAGE, base);
    write_reg(CFG_END_PAGE, base + 300);
    queue_request(MODE_INIT, '0, 1'b0);
    repeat (STACK_DEPTH + 4) queue_request(MODE_ALLOC, rand_page(), 1'b0);
    for (int i = 0; i <= STACK_DEPTH; i++)
      queue_request(MODE_FREE, base + STACK_DEPTH - i, 1'b0);
    queue_request(MODE_FREE, base + 5, 1'b0);
    queue_request(MODE_FREE, base + STACK_DEPTH + 4, 1'b0);
    queue_request(MODE_FREE, base + STACK_DEPTH + 3, 1'b0);
    repeat (3) queue_request(MODE_ALLOC, '0, 1'b0);
    settle();

    // Random phases, each with its own region setting.
    while (requests_queued < TARGET_ITEMS) begin
      span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      case ($urandom_range(0, 4))
        0: base = '0;
        1: base = PAGE_MAX - PAGE_W'($urandom_range(0, 50));
        2: base = PAGE_W'($urandom_range(0, 4000));
        default: base = rand_page();
      endcase
      sum = {1'b0, base} + (PAGE_W + 1)'(span);
      stop = sum[PAGE_W] ? PAGE_MAX : sum[PAGE_W-1:0];
      sel = $urandom_range(0, 9);
      if (sel == 0) stop = PAGE_MAX;
      else if (sel == 1) stop = base - PAGE_W'($urandom_range(0, 5));

      // Sometimes only the end moves, so a live end_page change is seen.
      if ($urandom_range(0, 4) != 0) write_reg(CFG_FIRST_PAGE, base);
      write_reg(CFG_END_PAGE, stop);
      if ($urandom_range(0, 19) < 17) queue_request(MODE_INIT, rand_page(), 1'b0);

      batch = $urandom_range(40, 90);
      repeat (batch) begin
        sel = $urandom_range(0, 99);
        if (sel < 42)
          queue_request(MODE_ALLOC, rand_page(), $urandom_range(0, 29) == 0);
        else if (sel < 88)
          queue_request(MODE_FREE, pick_page(region_first, span), $urandom_range(0, 29) == 0);
        else if (sel < 94)
          queue_request(MODE_INIT, rand_page(), 1'b0);
        else
          queue_request(MODE_UNDEF, rand_page(), 1'b0);
      end
      settle();
    end

    repeat (300) @(posedge clk);

    // Every accepted request must have produced its beat.
    if (expected_grants.size() != 0 || pending_requests.size() != 0) begin
      $display("%t: missing grants: expected %0d more, got 0",
               $time, expected_grants.size() + pending_requests.size());
      errors++;
    end

    if (errors == 0) begin
      $display("[page_frame_allocator] OK");
    end else begin
      $display("[page_frame_allocator] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_dp.sv
rtl/pfa_ctrl.sv
rtl/page_frame_allocator.sv
dv/tb_page_frame_allocator.sv
